FILE: rtl/lhnt_pkg.sv
// lhnt_pkg: request/response structs and hash constants for label_hash_node_table
// used by every rtl file through scoped names
package lhnt_pkg;

   localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;
   localparam logic [31:0] GOLDEN    = 32'h9E3779B9;
   localparam logic [31:0] FORCE_BIT = 32'h00010000;
   localparam logic [31:0] PERIOD_RESET = 32'd900000;

   localparam logic KIND_LABEL = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic CSR_AVOID  = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  label_byte;
      logic        byte_present;
      logic        label_last;
      logic [31:0] query_id;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] node_id;
      logic        due;
   } rsp_type;

   // job handed from front to back
   typedef struct packed {
      logic        kind;
      logic [31:0] id;
      logic [31:0] now_ms;
   } job_type;

   function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return 32'(x * FNV_PRIME);
   endfunction

   function automatic logic [31:0] prefix_seed();
      logic [31:0] h;
      h = fnv_step(FNV_BASIS, 8'h4D);
      h = fnv_step(h, 8'h43);
      h = fnv_step(h, 8'h7C);
      return h;
   endfunction

   function automatic logic reserved_id(logic [31:0] id);
      return (id <= 32'h000000FF) || (id == 32'hFFFFFFFF);
   endfunction

endpackage

FILE: rtl/lhnt_front.sv
// lhnt_front: hashes label bytes and nudges the final id, one multiply per nudge
// depends on lhnt_pkg
module lhnt_front #(
   parameter int NUDGE_LIMIT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  lhnt_pkg::req_type req_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       avoid_id,
   output lhnt_pkg::job_type job_data,
   output logic              job_valid,
   input  logic              job_ready
);
   localparam int NW = $clog2(NUDGE_LIMIT + 1);

   typedef enum logic [1:0] {S_IDLE, S_NUDGE, S_MUL, S_OUT} state_type;

   state_type         state_ff;
   logic [31:0]       hash_ff;
   logic [31:0]       id_ff;
   logic [31:0]       prod_ff;
   logic [NW-1:0]     cnt_ff;
   lhnt_pkg::job_type job_ff;
   logic              jv_ff;

   logic [31:0] hnext;
   logic        bad;
   logic [31:0] fixed;

   assign req_ready = (state_ff == S_IDLE) && !jv_ff;
   assign job_data  = job_ff;
   assign job_valid = jv_ff;
   assign hnext = req_data.byte_present ?
                  lhnt_pkg::fnv_step(hash_ff, req_data.label_byte) : hash_ff;
   assign bad   = lhnt_pkg::reserved_id(id_ff) || (id_ff == avoid_id);
   assign fixed = lhnt_pkg::reserved_id(prod_ff) ? (prod_ff | lhnt_pkg::FORCE_BIT) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hash_ff  <= lhnt_pkg::prefix_seed();
         jv_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (jv_ff && job_ready) jv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  if (req_data.kind == lhnt_pkg::KIND_QUERY) begin
                     job_ff <= '{lhnt_pkg::KIND_QUERY, req_data.query_id, req_data.now_ms};
                     jv_ff  <= 1'b1;
                  end else if (req_data.label_last) begin
                     id_ff    <= hnext;
                     hash_ff  <= lhnt_pkg::prefix_seed();
                     cnt_ff   <= '0;
                     state_ff <= S_NUDGE;
                  end else begin
                     hash_ff <= hnext;
                  end
               end
            end
            S_NUDGE: begin
               if (bad && (cnt_ff < NW'(NUDGE_LIMIT))) begin
                  prod_ff  <= 32'((id_ff ^ lhnt_pkg::GOLDEN) * lhnt_pkg::FNV_PRIME);
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_MUL: begin
               id_ff    <= fixed;
               state_ff <= S_NUDGE;
            end
            S_OUT: begin
               if (!jv_ff) begin
                  job_ff   <= '{lhnt_pkg::KIND_LABEL, id_ff, 32'd0};
                  jv_ff    <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/lhnt_back.sv
// lhnt_back: scans the id/stamp table one entry per cycle, inserts or answers due
// depends on lhnt_pkg
module lhnt_back #(
   parameter int ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  lhnt_pkg::job_type job_data,
   input  logic              job_valid,
   output logic              job_ready,
   input  logic [31:0]       period_ms,
   output lhnt_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_OUT} state_type;

   state_type         state_ff;
   lhnt_pkg::job_type job_ff;
   logic [CW-1:0]     idx_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [31:0]       node_mem [ENTRIES];
   logic [31:0]       stamp_mem [ENTRIES];
   logic [31:0]       node_rd_ff;
   logic [31:0]       stamp_rd_ff;
   logic              free_found_ff;
   logic [IW-1:0]     free_ff;
   logic [IW-1:0]     old_ff;
   logic [31:0]       old_stamp_ff;
   logic              hit_ff;
   logic [IW-1:0]     hit_idx_ff;
   logic [31:0]       hit_stamp_ff;
   lhnt_pkg::rsp_type rsp_ff;
   logic              full_ff;

   logic [IW-1:0] ix;
   logic [IW-1:0] rd_addr;
   logic          v;
   logic          due;
   logic [31:0]   elapsed;

   assign ix        = idx_ff[IW-1:0];
   // fetch the entry that the scan looks at next cycle
   assign rd_addr   = (state_ff == S_SCAN) ? IW'(idx_ff + 1'b1) : '0;
   assign v         = valid_ff[ix];
   assign job_ready = (state_ff == S_IDLE) && !full_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_empty = !full_ff;
   assign elapsed   = job_ff.now_ms - hit_stamp_ff;
   assign due       = (hit_stamp_ff == 32'd0) || (elapsed >= period_ms);

   always_ff @(posedge clock) begin
      node_rd_ff  <= node_mem[rd_addr];
      stamp_rd_ff <= stamp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         if (full_ff && rsp_pop) full_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (job_valid && job_ready) begin
                  job_ff        <= job_data;
                  idx_ff        <= '0;
                  free_found_ff <= 1'b0;
                  old_stamp_ff  <= 32'hFFFFFFFF;
                  old_ff        <= '0;
                  hit_ff        <= 1'b0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (v && node_rd_ff == job_ff.id) begin
                  hit_ff       <= 1'b1;
                  hit_idx_ff   <= ix;
                  hit_stamp_ff <= stamp_rd_ff;
                  state_ff     <= S_WRITE;
               end else begin
                  if (!v && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_ff       <= ix;
                  end else if (v && stamp_rd_ff <= old_stamp_ff) begin
                     old_stamp_ff <= stamp_rd_ff;
                     old_ff       <= ix;
                  end
                  if (idx_ff == CW'(ENTRIES - 1)) state_ff <= S_WRITE;
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_WRITE: begin
               rsp_ff.result_kind <= job_ff.kind;
               rsp_ff.node_id     <= job_ff.id;
               rsp_ff.due         <= 1'b0;
               if (job_ff.kind == lhnt_pkg::KIND_QUERY) begin
                  if (hit_ff && due) begin
                     stamp_mem[hit_idx_ff] <= (job_ff.now_ms != 32'd0) ? job_ff.now_ms : 32'd1;
                     rsp_ff.due <= 1'b1;
                  end
               end else if (!hit_ff) begin
                  node_mem[free_found_ff ? free_ff : old_ff]  <= job_ff.id;
                  stamp_mem[free_found_ff ? free_ff : old_ff] <= 32'd0;
                  valid_ff[free_found_ff ? free_ff : old_ff]  <= 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               full_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/label_hash_node_table.sv
// label_hash_node_table: top level, front hasher, one-entry job queue, table back end
// depends on lhnt_pkg, lhnt_front, lhnt_back
//
// usage: requests enter on req_push while req_full is low; a label byte that is
// not last is absorbed into the hash and gives no response. a last label element
// or any query gives one response, read from rsp_data while rsp_empty is low
// and removed with rsp_pop.
// a label end is nudged in the front (one multiply per nudge), then the back
// scans the table one entry a cycle, at most ENTRIES entries, then writes
// and posts the response. a query skips the nudge.
// throughput is set by the sequential table scan in the back end; the front can
// hash the next label's bytes, one per cycle while no job waits, as the back scans.
// reset clears the hash to the prefix seed, all valid bits, and registers to
// avoid_id 0 and period_ms 900000. when the receiver stalls the response holds,
// the back then stalls, and once the job register fills req_full rises.
module label_hash_node_table #(
   parameter int ENTRIES     = 16,
   parameter int NUDGE_LIMIT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  lhnt_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output lhnt_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   logic [31:0]       avoid_ff;
   logic [31:0]       period_ff;
   lhnt_pkg::job_type job_data;
   logic              job_valid;
   logic              job_ready;
   logic              req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         avoid_ff  <= 32'd0;
         period_ff <= lhnt_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lhnt_pkg::CSR_AVOID:  avoid_ff  <= csr_wdata;
            lhnt_pkg::CSR_PERIOD: period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_full = !req_ready;

   lhnt_front #(.NUDGE_LIMIT(NUDGE_LIMIT)) u_front (
      .clock, .reset, .req_data, .req_valid(req_push), .req_ready,
      .avoid_id(avoid_ff), .job_data, .job_valid, .job_ready
   );

   lhnt_back #(.ENTRIES(ENTRIES)) u_back (
      .clock, .reset, .job_data, .job_valid, .job_ready,
      .period_ms(period_ff), .rsp_data, .rsp_empty, .rsp_pop
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("response changed while waiting");
   a_label_no_due: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind == lhnt_pkg::KIND_LABEL) |-> !rsp_data.due)
      else $error("label response with due set");
   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      (job_valid && !job_ready) |=> job_valid)
      else $error("job dropped");
endmodule

FILE: verif/testbench.sv
// testbench for label_hash_node_table: label and due-query requests, checked against
// a behavioral model of the hash, nudge and oldest-stamp table; depends on lhnt_pkg
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE  = 16;
   localparam int NUDGE_MAX   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   lhnt_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   lhnt_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = lhnt_pkg::CSR_AVOID;
   logic [31:0] csr_wdata = '0;

   label_hash_node_table dut (.*);

   always #1 clock = ~clock;

   // model state
   logic [31:0] m_avoid, m_period, m_hash;
   logic        m_valid [TABLE_SIZE];
   logic [31:0] m_node [TABLE_SIZE];
   logic [31:0] m_stamp [TABLE_SIZE];

   lhnt_pkg::req_type pending_reqs[$];
   lhnt_pkg::rsp_type expected_rsps[$];
   logic [31:0] known_ids[$];
   int errors = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_recv = 1'b0;
   bit in_accepted = 1'b0;

   function automatic logic [31:0] hash_byte(logic [31:0] h, logic [7:0] b);
      return (h ^ {24'd0, b}) * 32'd16777619;
   endfunction

   function automatic logic is_reserved(logic [31:0] id);
      return id <= 32'hFF || id == 32'hFFFFFFFF;
   endfunction

   function automatic logic [31:0] seed_hash();
      return hash_byte(hash_byte(hash_byte(32'd2166136261, 8'h4D), 8'h43), 8'h7C);
   endfunction

   function automatic void table_reset();
      m_avoid = 0;
      m_period = 32'd900000;
      m_hash = seed_hash();
      for (int i = 0; i < TABLE_SIZE; i++) begin
         m_valid[i] = 0;
         m_node[i] = 0;
         m_stamp[i] = 0;
      end
   endfunction

   // returns 1 and fills r when the request produces a response
   function automatic bit map_request(lhnt_pkg::req_type q, output lhnt_pkg::rsp_type r);
      logic [31:0] id, oldest_stamp;
      int free_slot, oldest, n;
      bit found;
      r = '0;
      if (q.kind == lhnt_pkg::KIND_LABEL) begin
         if (q.byte_present) m_hash = hash_byte(m_hash, q.label_byte);
         if (!q.label_last) return 0;
         id = m_hash;
         m_hash = seed_hash();
         for (n = 0; n < NUDGE_MAX && (is_reserved(id) || id == m_avoid); n++) begin
            id = (id ^ 32'h9E3779B9) * 32'd16777619;
            if (is_reserved(id)) id |= 32'h00010000;
         end
         free_slot = -1;
         oldest = 0;
         oldest_stamp = 32'hFFFFFFFF;
         found = 0;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (m_valid[i] && m_node[i] == id) found = 1;
            if (!found) begin
               if (!m_valid[i]) begin
                  if (free_slot < 0) free_slot = i;
               end else if (m_stamp[i] <= oldest_stamp) begin
                  oldest_stamp = m_stamp[i];
                  oldest = i;
               end
            end
         end
         if (!found) begin
            n = (free_slot >= 0) ? free_slot : oldest;
            m_node[n] = id;
            m_stamp[n] = 0;
            m_valid[n] = 1;
            known_ids.push_back(id);
         end
         r.result_kind = lhnt_pkg::KIND_LABEL;
         r.node_id = id;
         r.due = 0;
      end else begin
         r.result_kind = lhnt_pkg::KIND_QUERY;
         r.node_id = q.query_id;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (m_valid[i] && m_node[i] == q.query_id) begin
               if (m_stamp[i] == 0 || (q.now_ms - m_stamp[i]) >= m_period) begin
                  m_stamp[i] = (q.now_ms != 0) ? q.now_ms : 32'd1;
                  r.due = 1;
               end
               break;
            end
         end
      end
      return 1;
   endfunction

   function automatic lhnt_pkg::req_type label_req(logic [7:0] b, logic present, logic last);
      lhnt_pkg::req_type q;
      q = '0;
      q.kind = lhnt_pkg::KIND_LABEL;
      q.label_byte = b;
      q.byte_present = present;
      q.label_last = last;
      q.query_id = $urandom;
      q.now_ms = $urandom;
      return q;
   endfunction

   function automatic lhnt_pkg::req_type query_req(logic [31:0] id, logic [31:0] now);
      lhnt_pkg::req_type q;
      q = '0;
      q.kind = lhnt_pkg::KIND_QUERY;
      q.label_byte = 8'($urandom);
      q.byte_present = 1'($urandom);
      q.label_last = 1'($urandom);
      q.query_id = id;
      q.now_ms = now;
      return q;
   endfunction

   // driver: holds a request until it is accepted, prediction at acceptance
   always @(negedge clock) begin
      if (!reset && (!req_push || in_accepted)) begin
         if (in_accepted) void'(pending_reqs.pop_front());
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_push <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            req_push <= 1'b0;
         end
      end
      rsp_pop <= !reset && !hold_recv && $urandom_range(99) >= recv_idle;
   end

   always @(posedge clock) begin
      lhnt_pkg::rsp_type r;
      in_accepted = !reset && req_push && !req_full;
      if (in_accepted) begin
         if (map_request(req_data, r)) expected_rsps.push_back(r);
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            r = expected_rsps.pop_front();
            if (rsp_data.result_kind !== r.result_kind || rsp_data.node_id !== r.node_id
                || rsp_data.due !== r.due) begin
               $display("%0t: mismatch expected kind %0d id %h due %0d, got kind %0d id %h due %0d",
                        $time, r.result_kind, r.node_id, r.due,
                        rsp_data.result_kind, rsp_data.node_id, rsp_data.due);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() != 0 || req_push || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == lhnt_pkg::CSR_AVOID) m_avoid = value;
      else m_period = value;
   endtask

   function automatic void add_label(int len);
      for (int i = 0; i < len; i++)
         pending_reqs.push_back(label_req(8'($urandom), $urandom_range(9) != 0,
                                          i == len - 1));
   endfunction

   function automatic void add_random(int count);
      logic [31:0] t;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: add_label($urandom_range(1, 4));
            4: pending_reqs.push_back(label_req(8'($urandom), 1'($urandom), 1'($urandom)));
            default: begin
               t = $urandom_range(3) == 0 ? $urandom : 32'd1000 * $urandom_range(5000);
               if (known_ids.size() != 0 && $urandom_range(4) != 0)
                  pending_reqs.push_back(query_req(
                     known_ids[$urandom_range(known_ids.size() - 1)], t));
               else
                  pending_reqs.push_back(query_req($urandom, t));
            end
         endcase
      end
   endfunction

   initial begin
      table_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extreme bytes, empty label, zero byte, two-byte label, queries
      pending_reqs.push_back(label_req(8'h00, 1, 1));
      pending_reqs.push_back(label_req(8'hFF, 1, 0));
      pending_reqs.push_back(label_req(8'h00, 0, 1));
      pending_reqs.push_back(label_req(8'h00, 0, 1));
      pending_reqs.push_back(label_req(8'hAA, 1, 0));
      pending_reqs.push_back(label_req(8'h55, 1, 1));
      pending_reqs.push_back(query_req(32'h0, 32'h0));
      pending_reqs.push_back(query_req(32'hFFFFFFFF, 32'hFFFFFFFF));
      drain();
      foreach (known_ids[i]) begin
         pending_reqs.push_back(query_req(known_ids[i], 32'h0));
         pending_reqs.push_back(query_req(known_ids[i], 32'hFFFFFFFF));
      end
      drain();
      // avoid the empty label's id so the nudge path runs
      csr_write(lhnt_pkg::CSR_AVOID, seed_hash());
      csr_write(lhnt_pkg::CSR_PERIOD, 32'd0);
      pending_reqs.push_back(label_req(8'h00, 0, 1));
      add_label(3);
      add_random(10);
      drain();
      // long receiver hold while the sender keeps offering
      hold_recv = 1'b1;
      add_random(60);
      repeat (400) @(posedge clock);
      hold_recv = 1'b0;
      drain();
      send_idle = 10; recv_idle = 75;
      csr_write(lhnt_pkg::CSR_AVOID, 32'hFFFFFFFF);
      csr_write(lhnt_pkg::CSR_PERIOD, 32'hFFFFFFFF);
      add_random(340);
      drain();
      send_idle = 75; recv_idle = 10;
      csr_write(lhnt_pkg::CSR_AVOID, $urandom);
      csr_write(lhnt_pkg::CSR_PERIOD, 32'd900000);
      add_random(340);
      drain();
      send_idle = 0; recv_idle = 0;
      csr_write(lhnt_pkg::CSR_AVOID, 32'h0);
      csr_write(lhnt_pkg::CSR_PERIOD, 32'd1500000);
      add_random(340);
      drain();
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end
endmodule

FILE: sim.f
rtl/lhnt_pkg.sv
rtl/lhnt_front.sv
rtl/lhnt_back.sv
rtl/label_hash_node_table.sv
verif/testbench.sv
